// ===== rtl/vosm_pkg.sv =====
`default_nettype none

package vosm_pkg;

	localparam int DEF_MAX_X = 64;
	localparam int DEF_MAX_Y = 64;
	localparam int DEF_MAX_Z = 32;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int ZCNT_W     = 7;
	localparam int ZIDX_W     = 6;

	localparam logic [CFG_IDX_W-1:0] REG_COUNT_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_Z = 2'd2;

	typedef enum logic [1:0] {
		KIND_CLEAR,
		KIND_MARK,
		KIND_QUERY,
		KIND_PROJECT
	} kind_t;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic              found;
		logic [ZIDX_W-1:0] z;
	} surface_t;

endpackage

`default_nettype wire

// ===== rtl/vosm_surface.sv =====
`default_nettype none

module vosm_surface #(
	parameter int MAX_Z = vosm_pkg::DEF_MAX_Z
) (
	input  wire logic [MAX_Z-1:0]            word,
	input  wire logic [vosm_pkg::ZCNT_W-1:0] cz,
	output vosm_pkg::surface_t               res
);
	import vosm_pkg::*;

	logic [MAX_Z-1:0]  cand;
	logic [MAX_Z-1:0]  onehot;
	logic [ZIDX_W-1:0] zsel;

	// A surface voxel is occupied with a free voxel above it inside the border.
	always_comb begin
		cand = '0;
		for (int k = 0; k < MAX_Z - 1; k++) begin
			cand[k] = word[k] & ~word[k+1] & (ZCNT_W'(k + 1) < cz);
		end
	end

	assign onehot = cand & (~cand + MAX_Z'(1));

	always_comb begin
		zsel = '0;
		for (int k = 0; k < MAX_Z; k++) begin
			if (onehot[k]) begin
				zsel = zsel | ZIDX_W'(k);
			end
		end
	end

	assign res.found = |cand;
	assign res.z     = zsel;

endmodule

`default_nettype wire

// ===== rtl/voxel_occupancy_surface_map.sv =====
`default_nettype none

// Occupancy voxel map with one MAX_Z-bit word per (x,y) column in a single-port-write
// synchronous RAM. A mark, query or project command taken when start is high and busy
// is low has its column word read at the accept edge, then modified, written back and
// reported at the next edge; busy is already low again in the cycle that done is high,
// so a new command can be taken while the previous result is shown. A clear command,
// and the initialization that follows reset, sweep every column word through the one
// write port, one word per cycle, with busy high;
// a clear reports its result at the end of the sweep. Every command produces exactly
// one result, shown for one cycle with done high; there is no way to stall it, so the
// receiver must take it in that cycle. Count registers may be written at any time
// through the configuration port, which is always ready; a command uses the counts
// that hold when it is accepted.
module voxel_occupancy_surface_map #(
	parameter int MAX_X = vosm_pkg::DEF_MAX_X,
	parameter int MAX_Y = vosm_pkg::DEF_MAX_Y,
	parameter int MAX_Z = vosm_pkg::DEF_MAX_Z
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [1:0]                          kind,
	input  wire logic [7:0]                          vox_x,
	input  wire logic [7:0]                          vox_y,
	input  wire logic [6:0]                          vox_z,
	output logic                                     done,
	output logic                                     is_free,
	output logic                                     found,
	output logic [4:0]                               surface_z,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [vosm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [vosm_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import vosm_pkg::*;

	localparam int N_COL = MAX_X * MAX_Y;
	localparam int AW    = (N_COL > 1) ? $clog2(N_COL) : 1;
	localparam int ZW    = $clog2(MAX_Z);
	localparam logic [AW-1:0] LAST_ADDR = AW'(N_COL - 1);

	state_t state_q, state_next;

	logic [6:0] count_x_q;
	logic [6:0] count_y_q;
	logic [5:0] count_z_q;

	logic [8:0]        cx;
	logic [8:0]        cy;
	logic [ZCNT_W-1:0] cz;

	logic            col_in;
	logic            z_in;
	logic [16:0]     idx_full;
	logic [AW-1:0]   rd_addr;
	logic            accept;

	kind_t             kind_q;
	logic              col_in_q;
	logic              z_in_q;
	logic [ZW-1:0]     zidx_q;
	logic [ZCNT_W-1:0] cz_q;
	logic [AW-1:0]     addr_q;
	logic [AW-1:0]     clr_addr_q;

	logic [MAX_Z-1:0] mem [N_COL];
	logic [MAX_Z-1:0] rd_data_s1;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [MAX_Z-1:0] mem_wdata;
	logic             clr_step;
	logic             fin_exec;
	logic             fin_clear;
	logic             occ;

	surface_t         surf;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_x_q <= 7'd64;
			count_y_q <= 7'd64;
			count_z_q <= 6'd32;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_COUNT_X: count_x_q <= cfg_data;
				REG_COUNT_Y: count_y_q <= cfg_data;
				REG_COUNT_Z: count_z_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	assign cx = (9'(count_x_q) > 9'(MAX_X)) ? 9'(MAX_X) : 9'(count_x_q);
	assign cy = (9'(count_y_q) > 9'(MAX_Y)) ? 9'(MAX_Y) : 9'(count_y_q);
	assign cz = (ZCNT_W'(count_z_q) > ZCNT_W'(MAX_Z)) ? ZCNT_W'(MAX_Z)
		: ZCNT_W'(count_z_q);

	assign col_in = !vox_x[7] && !vox_y[7] && ({1'b0, vox_x} < cx) && ({1'b0, vox_y} < cy);
	assign z_in   = !vox_z[6] && (ZCNT_W'(vox_z) < cz);

	assign idx_full = 17'(vox_x) * 17'(MAX_Y) + 17'(vox_y);
	assign rd_addr  = idx_full[AW-1:0];

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= kind_t'(kind);
			col_in_q <= col_in;
			z_in_q   <= z_in;
			zidx_q   <= vox_z[ZW-1:0];
			cz_q     <= cz;
			addr_q   <= rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (accept) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			clr_addr_q <= '0;
		end else begin
			state_q <= state_next;
			if (clr_step) begin
				clr_addr_q <= (clr_addr_q == LAST_ADDR) ? '0 : clr_addr_q + AW'(1);
			end
		end
	end

	always_comb begin
		state_next = state_q;
		mem_we     = 1'b0;
		mem_waddr  = addr_q;
		mem_wdata  = rd_data_s1 | (MAX_Z'(1) << zidx_q);
		clr_step   = 1'b0;
		fin_exec   = 1'b0;
		fin_clear  = 1'b0;
		case (state_q)
			ST_INIT, ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '0;
				clr_step  = 1'b1;
				if (clr_addr_q == LAST_ADDR) begin
					state_next = ST_IDLE;
					fin_clear  = (state_q == ST_CLEAR);
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_next = (kind_t'(kind) == KIND_CLEAR) ? ST_CLEAR : ST_EXEC;
				end
			end
			ST_EXEC: begin
				mem_we     = (kind_q == KIND_MARK) && col_in_q && z_in_q;
				fin_exec   = 1'b1;
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_INIT;
			end
		endcase
	end

	vosm_surface #(
		.MAX_Z(MAX_Z)
	) u_surface (
		.word(rd_data_s1),
		.cz  (cz_q),
		.res (surf)
	);

	assign occ = rd_data_s1[zidx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= fin_exec || fin_clear;
		end
	end

	always_ff @(posedge clk) begin
		is_free   <= fin_exec && (kind_q == KIND_QUERY) && col_in_q && z_in_q && !occ;
		found     <= fin_exec && (kind_q == KIND_PROJECT) && col_in_q && surf.found;
		surface_z <= (fin_exec && (kind_q == KIND_PROJECT) && col_in_q && surf.found)
			? surf.z[4:0] : 5'd0;
	end

endmodule

`default_nettype wire

// ===== tb/voxel_occupancy_surface_map_checker.sv =====
module voxel_occupancy_surface_map_checker
	import vosm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  logic [1:0]            kind,
	input  logic [7:0]            vox_x,
	input  logic [7:0]            vox_y,
	input  logic [6:0]            vox_z,
	input  logic                  done,
	input  logic                  is_free,
	input  logic                  found,
	input  logic [4:0]            surface_z,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    outstanding,
	output int                    surfaces
);

	localparam int MAX_X = DEF_MAX_X;
	localparam int MAX_Y = DEF_MAX_Y;
	localparam int MAX_Z = DEF_MAX_Z;
	localparam int SHOWN_MISMATCHES = 30;

	typedef struct packed {
		logic       is_free;
		logic       found;
		logic [4:0] surface_z;
	} column_result_t;

	logic [MAX_Z-1:0] col_word [MAX_X*MAX_Y];
	logic [6:0] cnt_x;
	logic [6:0] cnt_y;
	logic [5:0] cnt_z;
	column_result_t pending_results [$];
	int results_seen;

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= SHOWN_MISMATCHES)
			$display("mismatch at result %0d: %s is %0d, expected %0d", results_seen, what, got,
				want);
	endtask

	function automatic column_result_t execute_command(input kind_t k,
		input logic signed [7:0] x, input logic signed [7:0] y, input logic signed [6:0] z);
		column_result_t r;
		int lim_x;
		int lim_y;
		int lim_z;
		int col;
		logic in_col;
		logic in_z;
		logic [MAX_Z-1:0] w;
		r = '0;
		lim_x = (int'(cnt_x) > MAX_X) ? MAX_X : int'(cnt_x);
		lim_y = (int'(cnt_y) > MAX_Y) ? MAX_Y : int'(cnt_y);
		lim_z = (int'(cnt_z) > MAX_Z) ? MAX_Z : int'(cnt_z);
		in_col = (x >= 0) && (y >= 0) && (int'(x) < lim_x) && (int'(y) < lim_y);
		in_z = (z >= 0) && (int'(z) < lim_z);
		col = in_col ? int'(x) * MAX_Y + int'(y) : 0;
		w = col_word[col];
		case (k)
			KIND_CLEAR: begin
				for (int i = 0; i < MAX_X * MAX_Y; i++)
					col_word[i] = '0;
			end
			KIND_MARK: begin
				if (in_col && in_z)
					col_word[col][int'(z)] = 1'b1;
			end
			KIND_QUERY: begin
				if (in_col && in_z)
					r.is_free = !w[int'(z)];
			end
			default: begin
				if (in_col) begin
					for (int b = 0; b + 1 < lim_z; b++) begin
						if (!r.found && w[b] && !w[b+1]) begin
							r.found = 1'b1;
							r.surface_z = 5'(b);
						end
					end
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_X * MAX_Y; i++)
				col_word[i] = '0;
			cnt_x = 7'd64;
			cnt_y = 7'd64;
			cnt_z = 6'd32;
			pending_results.delete();
			results_seen = 0;
			errors = 0;
			surfaces = 0;
			outstanding <= 0;
		end else begin
			if (done) begin
				column_result_t want;
				results_seen++;
				if (pending_results.size() == 0) begin
					report_mismatch("result with no command pending, done", 1, 0);
				end else begin
					want = pending_results.pop_front();
					if (want.found)
						surfaces++;
					if (is_free !== want.is_free)
						report_mismatch("is_free", is_free, want.is_free);
					if (found !== want.found)
						report_mismatch("found", found, want.found);
					if (surface_z !== want.surface_z)
						report_mismatch("surface_z", surface_z, want.surface_z);
				end
			end
			if (start && !busy)
				pending_results = {pending_results,
					execute_command(kind_t'(kind), vox_x, vox_y, vox_z)};
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_COUNT_X: cnt_x = cfg_data;
					REG_COUNT_Y: cnt_y = cfg_data;
					REG_COUNT_Z: cnt_z = cfg_data[5:0];
					default: ;
				endcase
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

// ===== tb/voxel_occupancy_surface_map_test.sv =====
module voxel_occupancy_surface_map_test;
	import vosm_pkg::*;

	localparam int WATCHDOG_LIMIT = 25000;
	localparam int PHASES = 12;
	localparam int FIXED_PHASES = 9;
	localparam int PHASE_ITEMS = 115;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	kind_t kind = KIND_CLEAR;
	logic [7:0] vox_x = '0;
	logic [7:0] vox_y = '0;
	logic [6:0] vox_z = '0;
	logic done;
	logic is_free;
	logic found;
	logic [4:0] surface_z;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int errors;
	int outstanding;
	int surfaces;
	int lim_x = DEF_MAX_X;
	int lim_y = DEF_MAX_Y;
	int lim_z = DEF_MAX_Z;
	int issued [4] = '{0, 0, 0, 0};
	int reg_writes = 0;
	int idle_cycles = 0;
	bit burst = 1'b0;

	voxel_occupancy_surface_map dut (.*);

	voxel_occupancy_surface_map_checker map_monitor (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("voxel_occupancy_surface_map_test: errors");
			$finish;
		end
	end

	task automatic write_count(input logic [CFG_IDX_W-1:0] idx, input int data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data[CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		reg_writes++;
	endtask

	task automatic set_counts(input int x, input int y, input int zdata);
		write_count(REG_COUNT_X, x);
		write_count(REG_COUNT_Y, y);
		write_count(REG_COUNT_Z, zdata);
		cfg_valid <= 1'b0;
		lim_x = (x > DEF_MAX_X) ? DEF_MAX_X : x;
		lim_y = (y > DEF_MAX_Y) ? DEF_MAX_Y : y;
		lim_z = ((zdata & 63) > DEF_MAX_Z) ? DEF_MAX_Z : (zdata & 63);
	endtask

	task automatic command(input kind_t k, input int x, input int y, input int z);
		int gap;
		start <= 1'b1;
		kind <= k;
		vox_x <= x[7:0];
		vox_y <= y[7:0];
		vox_z <= z[6:0];
		@(posedge clk);
		while (busy)
			@(posedge clk);
		issued[int'(k)]++;
		gap = burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 || busy)
			@(posedge clk);
	endtask

	function automatic int coord(input int lim, input int focus);
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 2))
				0: return int'($urandom);
				1: return lim;
				default: return -1;
			endcase
		end
		if (lim == 0)
			return 0;
		if (focus != 0 && $urandom_range(0, 2) != 0)
			return $urandom_range(0, ((lim < focus) ? lim : focus) - 1);
		return $urandom_range(0, lim - 1);
	endfunction

	task automatic random_command();
		kind_t k;
		int r;
		r = $urandom_range(0, 999);
		if (r < 3)
			k = KIND_CLEAR;
		else if (r < 400)
			k = KIND_MARK;
		else if (r < 700)
			k = KIND_QUERY;
		else
			k = KIND_PROJECT;
		command(k, coord(lim_x, 4), coord(lim_y, 4), coord(lim_z, 0));
	endtask

	initial begin
		int set_x [FIXED_PHASES] = '{64, 1, 127, 0, 3, 8, 2, 4, 64};
		int set_y [FIXED_PHASES] = '{64, 1, 127, 5, 0, 8, 3, 4, 64};
		int set_z [FIXED_PHASES] = '{32, 1, 63, 8, 32, 0, 16, 32, 127};
		int px;
		int py;
		int pz;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);

		command(KIND_MARK, 0, 0, 0);
		command(KIND_MARK, 63, 63, 31);
		command(KIND_QUERY, 0, 0, 0);
		command(KIND_QUERY, 63, 63, 31);
		command(KIND_QUERY, 0, 0, 1);
		command(KIND_QUERY, 64, 0, 0);
		command(KIND_QUERY, 0, -1, 0);
		command(KIND_QUERY, 0, 0, 32);
		command(KIND_QUERY, 0, 0, -64);
		command(KIND_MARK, 127, -128, 5);
		command(KIND_QUERY, -128, 127, 63);
		command(KIND_PROJECT, 0, 0, -1);
		command(KIND_MARK, 0, 0, 1);
		command(KIND_PROJECT, 0, 0, 63);
		command(KIND_MARK, 1, 1, 30);
		command(KIND_MARK, 1, 1, 31);
		command(KIND_PROJECT, 1, 1, 0);
		command(KIND_PROJECT, 63, 63, 0);
		command(KIND_PROJECT, -1, 5, 0);
		command(KIND_QUERY, 1, 1, 30);
		command(KIND_CLEAR, -128, 127, -64);
		command(KIND_PROJECT, 0, 0, 0);
		command(KIND_QUERY, 63, 63, 31);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			if (p < FIXED_PHASES) begin
				px = set_x[p];
				py = set_y[p];
				pz = set_z[p];
			end else begin
				px = $urandom_range(1, 12);
				py = $urandom_range(1, 12);
				pz = $urandom_range(2, 32);
			end
			if (p == 0)
				write_count(REG_UNUSED, $urandom_range(0, 127));
			set_counts(px, py, pz);
			burst = ($urandom_range(0, 3) == 0);
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 59) == 0)
					drain();
				random_command();
			end
		end
		drain();
		repeat (6) @(posedge clk);

		$display("Ran %0d commands (%0d clear, %0d mark, %0d query, %0d project) over %0d %s",
			issued[0] + issued[1] + issued[2] + issued[3], issued[0], issued[1], issued[2],
			issued[3], reg_writes, "count register writes.");
		$display("%0d projections reported a surface voxel.", surfaces);
		if (errors == 0)
			$display("voxel_occupancy_surface_map_test: clean");
		else
			$display("voxel_occupancy_surface_map_test: errors");
		$finish;
	end

endmodule
